/* rtl/bsp_pkg.sv */
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the B-spline point evaluator.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int unsigned MaxDegree   = 3;
  localparam int unsigned MaxKnots    = 64;
  localparam int unsigned MaxControls = 64;

  localparam int unsigned KnotAw = $clog2(MaxKnots);
  localparam int unsigned CtrlAw = $clog2(MaxControls);
  localparam int unsigned KnotCw = 7;
  localparam int unsigned CtrlCw = 7;

  typedef enum logic [1:0] {
    CmdLoadKnot = 2'd0,
    CmdLoadCtrl = 2'd1,
    CmdEval     = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatEval    = 2'd0,
    StatNoCtrl  = 2'd1,
    StatFewKnot = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    RegDegree  = 2'd0,
    RegKnots   = 2'd1,
    RegCtrls   = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  slot;
    logic signed [31:0] knot_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] eval_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]  eval_status;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [6:0] data;
  } cfg_item_t;

  // Divider handshake. The denominator is a difference of two knots and
  // needs 33 bits.
  typedef struct packed {
    logic              start;
    logic signed [63:0] num;
    logic signed [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] alpha;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* rtl/bsp_if.sv */
// ----------------------------------------------------------------------------
// bsp_in_if / bsp_out_if / bsp_cfg_if
// Valid/ready channels of the evaluator.
// ----------------------------------------------------------------------------
interface bsp_in_if;
  logic valid;
  logic ready;
  bsp_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsp_out_if;
  logic valid;
  logic ready;
  bsp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsp_cfg_if;
  logic valid;
  logic ready;
  bsp_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/bsp_div.sv */
// ----------------------------------------------------------------------------
// bsp_div
// Restoring divider: one quotient bit per cycle, truncating toward zero,
// result saturated to 32-bit signed.
// ----------------------------------------------------------------------------
module bsp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsp_pkg::div_req_t req_i,
  output bsp_pkg::div_rsp_t rsp_o
);
  import bsp_pkg::*;

  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [64:0] qsigned;

  // Shift in one numerator bit and try the subtraction.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[63]} - {32'd0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num[63] ? 64'(-req_i.num) : 64'(req_i.num);
      den_d  = req_i.den[32] ? 33'(-req_i.den) : 33'(req_i.den);
      neg_d  = req_i.num[63] ^ req_i.den[32];
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign qsigned    = neg_q ? 65'(-{1'b0, quo_q}) : {1'b0, quo_q};
  assign rsp_o.done  = done_q;
  assign rsp_o.alpha = sat32(66'(signed'(qsigned)));

endmodule

/* rtl/bspline_de_boor_point_eval.sv */
// ----------------------------------------------------------------------------
// bspline_de_boor_point_eval
// B-spline point evaluator, De Boor's algorithm in signed Q16.16.
// ----------------------------------------------------------------------------
// Loads are accepted one per cycle while no result is waiting. An evaluation
// walks the knot store one candidate at a time, a read state and a compare
// state each, to find the span, fetches the p+1 working points with a read
// and a write state each, then for each of the p(p+1)/2 blend steps reads two
// knots, runs the shared 64-step divider (skipped where the two knots are
// equal) and three blend multiplies. The divider and the single-ported stores
// set the evaluation's run time. The input is not ready while an item is in
// work or a result is waiting.
module bspline_de_boor_point_eval (
  input  logic clk_i,
  input  logic rst_ni,
  bsp_in_if.sink    in_if,
  bsp_out_if.source out_if,
  bsp_cfg_if.sink   cfg_if
);
  import bsp_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StSpanRd, StSpanCmp, StLoadRd, StLoadWr, StLoRd, StHiRd,
    StDiv, StDivWait, StMul, StAcc, StCtrlRd, StDone
  } state_e;

  state_e state_q;

  logic [1:0]        deg_q;
  logic [KnotCw-1:0] nk_q;
  logic [CtrlCw-1:0] nc_q;
  logic [KnotCw-1:0] nk_eff;
  logic [CtrlCw-1:0] nc_eff;

  logic signed [31:0] knot_mem [MaxKnots];
  logic signed [31:0] cx_mem [MaxControls];
  logic signed [31:0] cy_mem [MaxControls];
  logic signed [31:0] cz_mem [MaxControls];
  logic signed [31:0] knot_rd_q, cx_rd_q, cy_rd_q, cz_rd_q;

  logic signed [31:0] wx_q [MaxDegree+1];
  logic signed [31:0] wy_q [MaxDegree+1];
  logic signed [31:0] wz_q [MaxDegree+1];

  in_item_t          item_q;
  out_item_t         res_q;
  logic              res_vld_q;
  logic [KnotCw-1:0] p_q, i_q, m_q;
  logic [1:0]        r_q, j_q;
  logic signed [31:0] lo_q, alpha_q;
  logic signed [63:0] px_q, py_q, pz_q;
  logic [KnotAw-1:0] kaddr;
  logic [CtrlAw-1:0] caddr;
  logic [KnotCw:0]   cidx;
  div_req_t          dreq;
  div_rsp_t          drsp;
  logic [KnotCw-1:0] lo_m, hi_m;
  logic              kval_zero;

  assign in_if.ready  = (state_q == StIdle) && !res_vld_q;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = res_vld_q;
  assign out_if.data  = res_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= 2'd3;
      nk_q  <= '0;
      nc_q  <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        RegDegree: deg_q <= cfg_if.data.data[1:0];
        RegKnots:  nk_q  <= cfg_if.data.data;
        RegCtrls:  nc_q  <= cfg_if.data.data;
        default: ;
      endcase
    end
  end

  // Counts above the store depths act as full stores.
  assign nk_eff = (nk_q > 7'(MaxKnots)) ? 7'(MaxKnots) : nk_q;
  assign nc_eff = (nc_q > 7'(MaxControls)) ? 7'(MaxControls) : nc_q;

  // Padded knot index m maps to raw m-1, or the last knot past n.
  function automatic logic [KnotAw-1:0] raw_of(input logic [KnotCw-1:0] m,
                                               input logic [KnotCw-1:0] n);
    logic [KnotCw-1:0] v;
    v = (m <= n) ? m - 1'b1 : n - 1'b1;
    return v[KnotAw-1:0];
  endfunction

  assign lo_m = 7'(j_q) + i_q - p_q;
  assign hi_m = 7'(j_q) + 7'd1 + i_q - 7'(r_q);
  always_comb begin
    kaddr = raw_of(m_q, nk_eff);
    if (state_q == StLoRd || state_q == StLoadWr) kaddr = raw_of(lo_m, nk_eff);
    if (state_q == StHiRd) kaddr = raw_of(hi_m, nk_eff);
    if (state_q == StLoRd || state_q == StLoadWr) kval_zero = lo_m <= p_q;
    else if (state_q == StHiRd) kval_zero = hi_m <= p_q;
    else kval_zero = m_q <= p_q;
    cidx = 8'(j_q) + 8'(i_q) - 8'(p_q);
    if (cidx >= 8'(nc_eff)) cidx = 8'(nc_eff) - 8'd1;
    caddr = cidx[CtrlAw-1:0];
  end

  // Stores: written by load commands, read with a registered port.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_if.valid && in_if.ready) begin
      if (in_if.data.command == CmdLoadKnot)
        knot_mem[in_if.data.slot[KnotAw-1:0]] <= in_if.data.knot_value;
      if (in_if.data.command == CmdLoadCtrl) begin
        cx_mem[in_if.data.slot[CtrlAw-1:0]] <= in_if.data.point_x;
        cy_mem[in_if.data.slot[CtrlAw-1:0]] <= in_if.data.point_y;
        cz_mem[in_if.data.slot[CtrlAw-1:0]] <= in_if.data.point_z;
      end
    end
    knot_rd_q <= kval_zero ? 32'sd0 : knot_mem[kaddr];
    cx_rd_q   <= cx_mem[caddr];
    cy_rd_q   <= cy_mem[caddr];
    cz_rd_q   <= cz_mem[caddr];
  end

  bsp_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // The divider only runs where the two knots differ.
  assign dreq.start = (state_q == StDiv) && (knot_rd_q != lo_q);
  assign dreq.num   = (64'(item_q.eval_time) - 64'(lo_q)) <<< 16;
  assign dreq.den   = 33'(knot_rd_q) - 33'(lo_q);

  function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                               input logic signed [63:0] prod);
    return sat32(66'(a) + 66'(prod >>> 16));
  endfunction

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      res_vld_q <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) res_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_if.valid && in_if.ready) begin
          item_q <= in_if.data;
          p_q    <= 7'(deg_q);
          if (in_if.data.command == CmdEval) begin
            if (nc_eff == '0) begin
              res_q <= '{32'sd0, 32'sd0, 32'sd0, StatNoCtrl};
              res_vld_q <= 1'b1;
            end else if (nk_eff == 7'd1 || nk_eff < 7'(deg_q) + 7'd1) begin
              j_q <= '0; i_q <= 7'(deg_q);
              state_q <= StCtrlRd;
            end else begin
              m_q <= 7'(deg_q);
              state_q <= StSpanRd;
            end
          end
        end
        StSpanRd: state_q <= StSpanCmp;
        StSpanCmp: begin
          if (m_q < nk_eff && knot_rd_q <= item_q.eval_time) begin
            m_q <= m_q + 7'd1;
            state_q <= StSpanRd;
          end else begin
            i_q <= (m_q > p_q) ? m_q - 7'd1 : p_q;
            j_q <= '0;
            state_q <= StLoadRd;
          end
        end
        StLoadRd: state_q <= StLoadWr;
        StLoadWr: begin
          wx_q[j_q] <= cx_rd_q; wy_q[j_q] <= cy_rd_q; wz_q[j_q] <= cz_rd_q;
          if (7'(j_q) == p_q) begin
            if (p_q == '0) state_q <= StDone;
            else begin
              r_q <= 2'd1; j_q <= p_q[1:0]; state_q <= StLoRd;
            end
          end else begin
            j_q <= j_q + 2'd1; state_q <= StLoadRd;
          end
        end
        StLoRd: state_q <= StHiRd;
        StHiRd: begin
          lo_q <= knot_rd_q; state_q <= StDiv;
        end
        StDiv: begin
          if (knot_rd_q == lo_q) begin
            alpha_q <= '0; state_q <= StMul;
          end else state_q <= StDivWait;
        end
        StDivWait: if (drsp.done) begin
          alpha_q <= drsp.alpha; state_q <= StMul;
        end
        StMul: begin
          px_q <= (64'(wx_q[j_q]) - 64'(wx_q[j_q-2'd1])) * 64'(alpha_q);
          py_q <= (64'(wy_q[j_q]) - 64'(wy_q[j_q-2'd1])) * 64'(alpha_q);
          pz_q <= (64'(wz_q[j_q]) - 64'(wz_q[j_q-2'd1])) * 64'(alpha_q);
          state_q <= StAcc;
        end
        StAcc: begin
          wx_q[j_q] <= blend(wx_q[j_q-2'd1], px_q);
          wy_q[j_q] <= blend(wy_q[j_q-2'd1], py_q);
          wz_q[j_q] <= blend(wz_q[j_q-2'd1], pz_q);
          if (j_q > r_q) begin
            j_q <= j_q - 2'd1; state_q <= StLoRd;
          end else if (7'(r_q) == p_q) state_q <= StDone;
          else begin
            r_q <= r_q + 2'd1; j_q <= p_q[1:0]; state_q <= StLoRd;
          end
        end
        // Control 0 is read here with j=0 and i=p now in place.
        StCtrlRd: state_q <= StDone;
        StDone: begin
          if (nk_eff == 7'd1 || nk_eff < p_q + 7'd1)
            res_q <= '{cx_rd_q, cy_rd_q, cz_rd_q, StatFewKnot};
          else
            res_q <= '{wx_q[p_q[1:0]], wy_q[p_q[1:0]], wz_q[p_q[1:0]], StatEval};
          res_vld_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

/* rtl/bsp_checker.sv */
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bsp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [1:0] out_status_i
);
  import bsp_pkg::*;

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= StatFewKnot) else $error("bad status");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input ready with result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
endmodule

bind bspline_de_boor_point_eval bsp_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_status_i(out_if.data.eval_status));

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the B-spline point evaluator. It fills the knot and
// point stores, then runs phases of register settings, each with evaluations and
// most with loads. Every evaluation is predicted in fixed point and checked
// field by field against the block's result. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bsp_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 700;
  localparam int unsigned TargetItems = 700;

  logic clk_i;
  logic rst_ni;

  bsp_in_if  in_if ();
  bsp_out_if out_if ();
  bsp_cfg_if cfg_if ();

  bspline_de_boor_point_eval dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // Mirror of the block's stores and registers.
  int knot_mem [MaxKnots];
  int px_mem [MaxControls];
  int py_mem [MaxControls];
  int pz_mem [MaxControls];
  int unsigned degree_q;
  int unsigned knots_q;
  int unsigned ctrls_q;

  in_item_t  pending_items [$];
  out_item_t expected_points [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned items_queued;
  logic in_fire;
  logic cfg_fire;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Padded knot sequence, built on the fly from the raw knots.
  function automatic longint padded_knot(int unsigned m, int unsigned n, int unsigned p);
    if (m <= p) return 0;
    if (m <= n) return longint'(knot_mem[m-1]);
    return longint'(knot_mem[n-1]);
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // a + floor(alpha * (b - a) / 65536), saturated.
  function automatic int blend_pair(int a, int b, longint alpha);
    longint diff;
    diff = longint'(b) - longint'(a);
    return clip32(longint'(a) + ((diff * alpha) >>> 16));
  endfunction

  function automatic out_item_t eval_point(logic signed [31:0] t_in);
    int unsigned p, n, c, i, j, r, idx;
    longint t, lo, hi, alpha;
    int wx [4];
    int wy [4];
    int wz [4];
    out_item_t res;
    p = (degree_q > MaxDegree) ? MaxDegree : degree_q;
    n = (knots_q > MaxKnots) ? MaxKnots : knots_q;
    c = (ctrls_q > MaxControls) ? MaxControls : ctrls_q;
    t = longint'(t_in);
    if (c == 0) begin
      res.out_x = '0;
      res.out_y = '0;
      res.out_z = '0;
      res.eval_status = StatNoCtrl;
    end else if (n == 1 || n < p + 1) begin
      res.out_x = px_mem[0];
      res.out_y = py_mem[0];
      res.out_z = pz_mem[0];
      res.eval_status = StatFewKnot;
    end else begin
      i = p;
      while (i < n && padded_knot(i, n, p) <= t) i++;
      i = (i > p) ? i - 1 : p;
      for (j = 0; j <= p; j++) begin
        idx = j + i - p;
        if (idx >= c) idx = c - 1;
        wx[j] = px_mem[idx];
        wy[j] = py_mem[idx];
        wz[j] = pz_mem[idx];
      end
      for (r = 1; r <= p; r++) begin
        for (j = p; j >= r; j--) begin
          lo = padded_knot(j + i - p, n, p);
          hi = padded_knot(j + 1 + i - r, n, p);
          alpha = 0;
          if (hi != lo) alpha = clip32(((t - lo) * 65536) / (hi - lo));
          wx[j] = blend_pair(wx[j-1], wx[j], alpha);
          wy[j] = blend_pair(wy[j-1], wy[j], alpha);
          wz[j] = blend_pair(wz[j-1], wz[j], alpha);
        end
      end
      res.out_x = wx[p];
      res.out_y = wy[p];
      res.out_z = wz[p];
      res.eval_status = StatEval;
    end
    return res;
  endfunction

  // Sampling at the rising edge: register writes, accepted items, results.
  always @(posedge clk_i) begin
    out_item_t exp_pt;
    out_item_t got;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
    in_fire  <= rst_ni && in_if.valid && in_if.ready;
    cfg_fire <= rst_ni && cfg_if.valid && cfg_if.ready;
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.data.index)
        RegDegree: degree_q = cfg_if.data.data[1:0];
        RegKnots:  knots_q  = cfg_if.data.data;
        RegCtrls:  ctrls_q  = cfg_if.data.data;
        default: ;
      endcase
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      case (in_if.data.command)
        CmdLoadKnot: knot_mem[in_if.data.slot] = in_if.data.knot_value;
        CmdLoadCtrl: begin
          px_mem[in_if.data.slot] = in_if.data.point_x;
          py_mem[in_if.data.slot] = in_if.data.point_y;
          pz_mem[in_if.data.slot] = in_if.data.point_z;
        end
        CmdEval: expected_points.insert(expected_points.size(),
                                        eval_point(in_if.data.eval_time));
        default: ;
      endcase
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_points.size() == 0) begin
        $error("result transaction with no evaluation outstanding");
        fail_count++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (got.out_x !== exp_pt.out_x) begin
          $error("out_x expected %0d actual %0d", exp_pt.out_x, got.out_x);
          fail_count++;
        end
        if (got.out_y !== exp_pt.out_y) begin
          $error("out_y expected %0d actual %0d", exp_pt.out_y, got.out_y);
          fail_count++;
        end
        if (got.out_z !== exp_pt.out_z) begin
          $error("out_z expected %0d actual %0d", exp_pt.out_z, got.out_z);
          fail_count++;
        end
        if (got.eval_status !== exp_pt.eval_status) begin
          $error("eval_status expected %0d actual %0d", exp_pt.eval_status,
                 got.eval_status);
          fail_count++;
        end
      end
    end
  end

  // Input driver: bursts of transactions separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid = 1'b0;
    end else begin
      if (in_if.valid && in_fire) in_if.valid = 1'b0;
      if (!in_if.valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          in_if.data  = pending_items.pop_front();
          in_if.valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Result receiver: stalls of random length, with quiet stretches.
  int unsigned stall_left;
  int unsigned quiet_left;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready = 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = 1'b1;
      if (quiet_left > 0) begin
        quiet_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 40);
      end else if ($urandom_range(0, 15) == 0) begin
        quiet_left = $urandom_range(50, 400);
      end
    end
  end

  task automatic queue_item(cmd_e cmd, int unsigned slot, int knot, int x, int y, int z,
                            int t);
    in_item_t it;
    it.command    = cmd;
    it.slot       = slot[5:0];
    it.knot_value = knot;
    it.point_x    = x;
    it.point_y    = y;
    it.point_z    = z;
    it.eval_time  = t;
    pending_items.insert(pending_items.size(), it);
    items_queued++;
  endtask

  task automatic queue_knot(int unsigned slot, int knot);
    queue_item(CmdLoadKnot, slot, knot, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic queue_ctrl(int unsigned slot, int x, int y, int z);
    queue_item(CmdLoadCtrl, slot, $urandom, x, y, z, $urandom);
  endtask

  task automatic queue_eval(int t);
    queue_item(CmdEval, $urandom, $urandom, $urandom, $urandom, $urandom, t);
  endtask

  // Waits until everything queued has gone and been answered, then lets the
  // block settle before returning.
  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_if.valid || expected_points.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int unsigned val);
    cfg_if.data.index = idx;
    cfg_if.data.data  = val[6:0];
    cfg_if.valid = 1'b1;
    @(negedge clk_i);
    while (!cfg_fire) @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_regs(int unsigned deg, int unsigned nk, int unsigned nc);
    wait_quiet();
    write_reg(RegDegree, deg);
    write_reg(RegKnots, nk);
    write_reg(RegCtrls, nc);
  endtask

  // Random control value: mostly moderate, sometimes at the extremes.
  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  // Non-decreasing knots with repeats; occasionally a random, unordered set.
  task automatic load_knots(int unsigned count, output int first_k, output int last_k);
    longint k;
    int unsigned s;
    bit unordered;
    unordered = ($urandom_range(0, 9) == 0);
    k = $signed($urandom_range(0, 8 << 16)) - (2 << 16);
    first_k = int'(k);
    for (s = 0; s < count; s++) begin
      if (unordered) begin
        k = $signed($urandom);
      end else begin
        case ($urandom_range(0, 5))
          0: k = k;
          1: k = k + $urandom_range(1, 32'h7fffff);
          default: k = k + ($urandom_range(1, 3) << 16);
        endcase
        if (k > 64'sd2147483647) k = 64'sd2147483647;
      end
      queue_knot(s, int'(k));
      last_k = int'(k);
    end
  endtask

  initial begin
    int unsigned s, deg, nk, nc, e;
    int first_k, last_k;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    burst_left = 0;
    gap_left = 0;
    stall_left = 0;
    quiet_left = 0;
    fail_count = 0;
    cycle_count = 0;
    items_queued = 0;
    in_fire = 1'b0;
    cfg_fire = 1'b0;
    degree_q = 3;
    knots_q = 0;
    ctrls_q = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every store entry is written before anything can read it.
    for (s = 0; s < MaxKnots; s++) queue_knot(s, int'(s) << 16);
    for (s = 0; s < MaxControls; s++)
      queue_ctrl(s, rand_coord(), rand_coord(), rand_coord());

    // Directed: reset counts mean no controls; then extremes and short cases.
    queue_eval(0);
    queue_eval(32'sh7fffffff);
    queue_item(CmdNone, 6'h3f, $urandom, $urandom, $urandom, $urandom, $urandom);
    set_regs(3, 1, 4);
    queue_eval(32'sh80000000);
    set_regs(2, 2, 4);
    queue_eval(1 << 16);
    set_regs(0, 0, 1);
    queue_eval(0);
    set_regs(3, 127, 127);
    queue_ctrl(63, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    queue_ctrl(0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    queue_knot(63, 32'sh7fffffff);
    queue_eval(32'sh80000000);
    queue_eval(32'sh7fffffff);
    queue_eval(40 << 16);
    set_regs(1, 64, 64);
    queue_eval(63 << 16);
    queue_eval(17 << 16);
    set_regs(0, 65, 2);
    queue_eval(30 << 16);
    set_regs(3, 4, 1);
    queue_eval(2 << 16);

    // Random phases: a setting, fresh knots and some fresh points, then evaluations mixed with loads and no-op items.
    while (items_queued < TargetItems) begin
      deg = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0: nk = $urandom_range(0, 3);
        1: nk = $urandom_range(65, 127);
        2: nk = 64;
        default: nk = $urandom_range(deg + 1, 12);
      endcase
      case ($urandom_range(0, 9))
        0: nc = 0;
        1: nc = $urandom_range(65, 127);
        2: nc = 1;
        default: nc = $urandom_range(1, 16);
      endcase
      set_regs(deg, nk, nc);
      load_knots((nk > MaxKnots) ? MaxKnots : nk, first_k, last_k);
      for (s = 0; s < ((nc > MaxControls) ? MaxControls : nc); s++)
        if ($urandom_range(0, 1) == 0) queue_ctrl(s, rand_coord(), rand_coord(), rand_coord());
      for (e = 0; e < 14; e++) begin
        case ($urandom_range(0, 9))
          0: queue_eval($urandom);
          1: queue_item(CmdNone, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          2: queue_ctrl($urandom_range(0, 63), rand_coord(), rand_coord(), rand_coord());
          3: queue_knot($urandom_range(0, 63), $urandom);
          default: begin
            if (first_k < last_k)
              queue_eval(int'(longint'(first_k) - 32'h10000 +
                              longint'($urandom) % (longint'(last_k) - first_k + 32'h20000)));
            else
              queue_eval(first_k + $signed($urandom_range(0, 32'h40000)) - 32'sh20000);
          end
        endcase
      end
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
